### hw/rtl/acdz_pkg.sv
// Shared types, constants and register map of the auto-centering dead zone corrector.
`default_nettype none

package acdz_pkg;

  // Number of samples averaged to find the wheel center (2 to 64).
  localparam int CenterSamples = 64;

  localparam int SampleW = 10;
  localparam int CountW  = 16;
  localparam int AccW    = 16;
  localparam int LeftW   = 7;
  localparam int CfgIdxW = 3;
  localparam int CfgW    = 16;

  // Exact floor division of the accumulator by CenterSamples through a
  // reciprocal: the shift covers the accumulator width plus log2 of the divisor.
  localparam int CenterShift  = AccW + $clog2(CenterSamples);
  localparam int CenterRecipW = 17;
  localparam int CenterProdW  = AccW + CenterRecipW;
  localparam logic [CenterRecipW-1:0] CenterRecip =
      CenterRecipW'(((1 << CenterShift) + CenterSamples - 1) / CenterSamples);
  localparam logic [LeftW-1:0] SamplesInit = LeftW'(CenterSamples);

  localparam logic [SampleW-1:0] Midpoint  = 10'd512;
  localparam logic [SampleW-1:0] LowLimit  = 10'd256;
  localparam logic [SampleW-1:0] HighLimit = 10'd768;
  localparam logic [SampleW-1:0] DutyMax   = 10'd1023;

  // Register indexes.
  localparam logic [CfgIdxW-1:0] RegSettleWait  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegSettleWin   = 3'd1;
  localparam logic [CfgIdxW-1:0] RegDeadBand    = 3'd2;
  localparam logic [CfgIdxW-1:0] RegPushOffset  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegGain        = 3'd4;
  localparam logic [CfgIdxW-1:0] RegStoredCorr  = 3'd5;

  // Phase codes as seen on the result word.
  localparam logic [1:0] PhaseInit = 2'd0;
  localparam logic [1:0] PhaseWait = 2'd1;
  localparam logic [1:0] PhaseCal  = 2'd2;
  localparam logic [1:0] PhaseWork = 2'd3;

  typedef enum logic [3:0] {
    PH_INIT = 4'b0001,
    PH_WAIT = 4'b0010,
    PH_CAL  = 4'b0100,
    PH_WORK = 4'b1000
  } phase_e;

  typedef struct packed {
    logic [15:0] settle_wait;
    logic [8:0]  settle_window;
    logic [7:0]  dead_band;
    logic [8:0]  push_offset;
    logic [4:0]  gain;
    logic        stored_corr;
  } cfg_t;

  typedef struct packed {
    logic       duty_en;
    logic       corr_on;
    logic       save;
    logic [1:0] phase;
  } seq_res_t;

endpackage

`default_nettype wire

### hw/rtl/acdz_cfg_regs.sv
// Configuration register file of the dead zone corrector.
`default_nettype none

module acdz_cfg_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [acdz_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [acdz_pkg::CfgW-1:0]     cfg_wdata_i,
  output acdz_pkg::cfg_t                     cfg_o
);
  import acdz_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        RegSettleWait: cfg_d.settle_wait   = cfg_wdata_i;
        RegSettleWin:  cfg_d.settle_window = cfg_wdata_i[8:0];
        RegDeadBand:   cfg_d.dead_band     = cfg_wdata_i[7:0];
        RegPushOffset: cfg_d.push_offset   = cfg_wdata_i[8:0];
        RegGain:       cfg_d.gain          = cfg_wdata_i[4:0];
        RegStoredCorr: cfg_d.stored_corr   = cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.settle_wait   <= 16'd20000;
      cfg_q.settle_window <= 9'd128;
      cfg_q.dead_band     <= 8'd5;
      cfg_q.push_offset   <= 9'd60;
      cfg_q.gain          <= 5'd6;
      cfg_q.stored_corr   <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### hw/rtl/acdz_seq.sv
// Mode sequencer: correction choice, settle wait, center averaging.
`default_nettype none

module acdz_seq (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          step_i,
  input  wire logic [acdz_pkg::SampleW-1:0]  sample_i,
  input  wire acdz_pkg::cfg_t                cfg_i,
  output acdz_pkg::seq_res_t                 res_o,
  output logic [acdz_pkg::SampleW-1:0]       center_o,
  output logic                               flag_o
);
  import acdz_pkg::*;

  phase_e               phase_q, phase_d;
  logic                 flag_q, flag_d;
  logic [CountW-1:0]    cnt_q, cnt_d;
  logic [AccW-1:0]      acc_q, acc_d;
  logic [SampleW-1:0]   center_q, center_d;
  logic [LeftW-1:0]     left_q, left_d;

  logic [SampleW-1:0]     mid_dist;
  logic [CountW-1:0]      cnt_dec;
  logic [AccW-1:0]        acc_sum;
  logic [LeftW-1:0]       left_dec;
  logic [CenterProdW-1:0] center_prod;

  assign mid_dist    = (sample_i >= Midpoint) ? sample_i - Midpoint : Midpoint - sample_i;
  assign cnt_dec     = cnt_q - 16'd1;
  assign acc_sum     = acc_q + AccW'(sample_i);
  assign left_dec    = left_q - 7'd1;
  assign center_prod = CenterProdW'(acc_sum) * CenterProdW'(CenterRecip);

  always_comb begin
    phase_d     = phase_q;
    flag_d      = flag_q;
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    center_d    = center_q;
    left_d      = left_q;
    res_o       = '0;
    case (phase_q)
      PH_INIT: begin
        phase_d   = PH_WAIT;
        res_o.save = 1'b1;
        if (sample_i < LowLimit) begin
          flag_d = 1'b1;
          cnt_d  = cfg_i.settle_wait;
        end else if (sample_i >= HighLimit) begin
          flag_d = 1'b0;
          cnt_d  = cfg_i.settle_wait;
        end else begin
          // Mid-range start keeps the stored flag and waits half as long.
          flag_d = cfg_i.stored_corr;
          cnt_d  = cfg_i.settle_wait >> 1;
        end
      end
      PH_WAIT: begin
        if (mid_dist > {1'b0, cfg_i.settle_window}) begin
          cnt_d = cfg_i.settle_wait;
        end else begin
          cnt_d = cnt_dec;
          if (cnt_dec == '0) begin
            acc_d   = '0;
            left_d  = SamplesInit;
            phase_d = PH_CAL;
          end
        end
      end
      PH_CAL: begin
        acc_d  = acc_sum;
        left_d = left_dec;
        if (left_dec == '0) begin
          center_d = center_prod[CenterShift +: SampleW];
          phase_d  = PH_WORK;
        end
      end
      PH_WORK: begin
        res_o.duty_en = 1'b1;
      end
      default: begin
        phase_d = PH_INIT;
      end
    endcase
    res_o.corr_on = flag_d;
    case (phase_d)
      PH_INIT: res_o.phase = PhaseInit;
      PH_WAIT: res_o.phase = PhaseWait;
      PH_CAL:  res_o.phase = PhaseCal;
      PH_WORK: res_o.phase = PhaseWork;
      default: res_o.phase = PhaseInit;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_INIT;
      flag_q   <= 1'b1;
      cnt_q    <= '0;
      acc_q    <= '0;
      center_q <= '0;
      left_q   <= SamplesInit;
    end else if (step_i) begin
      phase_q  <= phase_d;
      flag_q   <= flag_d;
      cnt_q    <= cnt_d;
      acc_q    <= acc_d;
      center_q <= center_d;
      left_q   <= left_d;
    end
  end

  assign center_o = center_q;
  assign flag_o   = flag_q;

endmodule

`default_nettype wire

### hw/rtl/acdz_duty.sv
// Duty datapath: centering, dead band, gain, push offset and saturation.
`default_nettype none

module acdz_duty (
  input  wire logic [acdz_pkg::SampleW-1:0]  sample_i,
  input  wire logic [acdz_pkg::SampleW-1:0]  center_i,
  input  wire logic                          flag_i,
  input  wire acdz_pkg::cfg_t                cfg_i,
  output logic [acdz_pkg::SampleW-1:0]       duty_o
);
  import acdz_pkg::*;

  logic signed [SampleW:0] diff;
  logic                    neg;
  logic [SampleW-1:0]      mag;
  logic [SampleW-1:0]      banded;
  logic [14:0]             prod;
  logic [11:0]             scaled;
  logic [12:0]             pushed;
  logic [12:0]             r;

  // The work is done on the magnitude; the sign only picks the side of 512.
  assign diff   = $signed({1'b0, sample_i}) - $signed({1'b0, center_i});
  assign neg    = diff[SampleW];
  assign mag    = neg ? SampleW'(-diff) : diff[SampleW-1:0];
  assign banded = (mag > SampleW'(cfg_i.dead_band)) ? mag - SampleW'(cfg_i.dead_band) : '0;
  assign prod   = 15'(banded) * 15'(cfg_i.gain);
  assign scaled = prod[14:3];
  assign pushed = (scaled == '0) ? '0 : 13'(scaled) + 13'(cfg_i.push_offset);
  assign r      = flag_i ? pushed : 13'(mag);

  always_comb begin
    if (neg) begin
      duty_o = (r >= 13'(Midpoint)) ? '0 : Midpoint - r[SampleW-1:0];
    end else begin
      duty_o = (r >= 13'd511) ? DutyMax : Midpoint + r[SampleW-1:0];
    end
  end

endmodule

`default_nettype wire

### hw/rtl/auto_centering_dead_zone_corrector.sv
// Top level of the auto-centering dead zone corrector.
//
//   Channel   Direction  Handshake                     Payload
//   input     in         in_valid_i / in_ready_o       position_sample_i
//   result    out        out_valid_o / out_ready_i     drive_duty_o, duty_valid_o,
//                                                      correction_on_o, save_setting_o,
//                                                      phase_o
//   config    in         cfg_we_i (no wait)            cfg_idx_i, cfg_wdata_i
//
// One word per cycle sustained while out_ready_i is high; an accepted word waits in the
// input register, then passes the mode logic and the single gain multiply into the result
// register once that is free. Reset restores register defaults and the init mode at once.
// A stalled result holds its register while one more word may wait in the input register.
`default_nettype none

module auto_centering_dead_zone_corrector (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [acdz_pkg::SampleW-1:0]  position_sample_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [acdz_pkg::SampleW-1:0]       drive_duty_o,
  output logic                               duty_valid_o,
  output logic                               correction_on_o,
  output logic                               save_setting_o,
  output logic [1:0]                         phase_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [acdz_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [acdz_pkg::CfgW-1:0]     cfg_wdata_i
);
  import acdz_pkg::*;

  cfg_t               cfg;
  seq_res_t           seq_res;
  logic [SampleW-1:0] center;
  logic               flag;
  logic [SampleW-1:0] duty;

  logic               s1_valid_q, s1_valid_d;
  logic [SampleW-1:0] s1_sample_q;
  logic               s1_adv;
  logic               out_valid_q, out_valid_d;
  logic [SampleW-1:0] duty_q;
  seq_res_t           res_q;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || !out_valid_q || out_ready_i;

  assign s1_valid_d  = (in_valid_i && in_ready_o) ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
  assign out_valid_d = s1_adv ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  acdz_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  acdz_seq u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (s1_adv),
    .sample_i (s1_sample_q),
    .cfg_i    (cfg),
    .res_o    (seq_res),
    .center_o (center),
    .flag_o   (flag)
  );

  acdz_duty u_duty (
    .sample_i (s1_sample_q),
    .center_i (center),
    .flag_i   (flag),
    .cfg_i    (cfg),
    .duty_o   (duty)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_sample_q <= position_sample_i;
    end
    if (s1_adv) begin
      res_q  <= seq_res;
      duty_q <= seq_res.duty_en ? duty : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign drive_duty_o    = duty_q;
  assign duty_valid_o    = res_q.duty_en;
  assign correction_on_o = res_q.corr_on;
  assign save_setting_o  = res_q.save;
  assign phase_o         = res_q.phase;

`ifndef SYNTH
  // Outside the working mode the duty field is forced to zero.
  a_duty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !duty_valid_o |-> drive_duty_o == '0)
    else $error("duty nonzero outside working mode");

  // The init word always leaves the block in the waiting mode.
  a_save_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && save_setting_o |-> phase_o == PhaseWait && !duty_valid_o)
    else $error("save word not followed by waiting mode");

  // A duty is only issued in the working mode.
  a_duty_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && duty_valid_o |-> phase_o == PhaseWork)
    else $error("duty issued outside working mode");

  // A word held in the input register is not dropped while the result stalls.
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_sample_q))
    else $error("stalled input word lost");
`endif

endmodule

`default_nettype wire

### tb/tb_auto_centering_dead_zone_corrector.sv
// Testbench for the dead zone corrector: directed plan, then random words checked against a model.
`default_nettype none

module tb_auto_centering_dead_zone_corrector;
  import acdz_pkg::*;

  localparam int StallLimit = 2000;
  localparam int SettleCycles = 4;

  // Register indexes outside the map; writes to them must change nothing.
  localparam logic [CfgIdxW-1:0] RegSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] RegSpareHi = 3'd7;

  typedef struct packed {
    logic [SampleW-1:0] duty;
    logic               valid;
    logic               corr;
    logic               save;
    logic [1:0]         phase;
  } duty_word_t;

  typedef struct packed {
    logic               is_reg;
    logic [CfgIdxW-1:0] idx;
    logic [CfgW-1:0]    data;
    logic [SampleW-1:0] sample;
    logic               typed;
    duty_word_t         canned;
  } plan_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [SampleW-1:0] position_sample_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [SampleW-1:0] drive_duty_o;
  logic               duty_valid_o;
  logic               correction_on_o;
  logic               save_setting_o;
  logic [1:0]         phase_o;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0]    cfg_wdata_i;

  auto_centering_dead_zone_corrector u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .position_sample_i (position_sample_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .drive_duty_o      (drive_duty_o),
    .duty_valid_o      (duty_valid_o),
    .correction_on_o   (correction_on_o),
    .save_setting_o    (save_setting_o),
    .phase_o           (phase_o),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_wdata_i       (cfg_wdata_i)
  );

  // Model state of the corrector.
  cfg_t               cfg_m;
  logic [1:0]         ph_m;
  logic               corr_m;
  logic [CountW-1:0]  settle_m;
  logic [AccW-1:0]    acc_m;
  logic [SampleW-1:0] center_m;
  logic [LeftW-1:0]   left_m;

  duty_word_t pending_words[$];
  plan_row_t  plan[$];
  int         mismatches;
  int         idle_cycles;
  bit         calm;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic duty_word_t predict_word(input logic [SampleW-1:0] s);
    duty_word_t         w;
    logic [SampleW-1:0] mid_dist;
    int                 v;
    int                 band;
    w = '0;
    case (ph_m)
      PhaseInit: begin
        ph_m = PhaseWait;
        settle_m = cfg_m.settle_wait;
        if (s < LowLimit) begin
          corr_m = 1'b1;
        end else if (s >= HighLimit) begin
          corr_m = 1'b0;
        end else begin
          settle_m = settle_m >> 1;
          corr_m = cfg_m.stored_corr;
        end
        w.save = 1'b1;
      end
      PhaseWait: begin
        mid_dist = (s >= Midpoint) ? s - Midpoint : Midpoint - s;
        if (mid_dist > cfg_m.settle_window) begin
          settle_m = cfg_m.settle_wait;
        end else begin
          settle_m = settle_m - 1'b1;
          if (settle_m == '0) begin
            acc_m = '0;
            left_m = SamplesInit;
            ph_m = PhaseCal;
          end
        end
      end
      PhaseCal: begin
        acc_m = acc_m + AccW'(s);
        left_m = left_m - 1'b1;
        if (left_m == '0) begin
          center_m = SampleW'(acc_m / CenterSamples);
          ph_m = PhaseWork;
        end
      end
      default: begin
        v = int'(s) - int'(center_m);
        if (corr_m) begin
          band = int'(cfg_m.dead_band);
          if (v > 0) begin
            v = (v < band) ? 0 : v - band;
          end else if (v < 0) begin
            v = (v > -band) ? 0 : v + band;
          end
          // Signed division truncates toward zero, as the gain stage does.
          v = (v * int'(cfg_m.gain)) / 8;
          if (v > 0) begin
            v = v + int'(cfg_m.push_offset);
          end else if (v < 0) begin
            v = v - int'(cfg_m.push_offset);
          end
        end
        v = v + 512;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        w.duty = SampleW'(v);
        w.valid = 1'b1;
      end
    endcase
    w.corr = corr_m;
    w.phase = ph_m;
    return w;
  endfunction

  function automatic void plan_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    plan_row_t r;
    r = '0;
    r.is_reg = 1'b1;
    r.idx = idx;
    r.data = data;
    plan.push_back(r);
  endfunction

  // A typed row is never in the working mode, so its duty word is zero apart from save
  // and phase; the correction flag is taken from the model since only the first word sets it.
  function automatic void plan_sample(input logic [SampleW-1:0] s, input logic typed,
                                      input logic save, input logic [1:0] ph);
    plan_row_t r;
    r = '0;
    r.sample = s;
    r.typed = typed;
    r.canned.save = save;
    r.canned.phase = ph;
    plan.push_back(r);
  endfunction

  task automatic drive_sample(input logic [SampleW-1:0] s, input logic typed,
                              input duty_word_t canned);
    duty_word_t w;
    @(negedge clk_i);
    while (!calm && $urandom_range(0, 99) < 18) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    position_sample_i <= s;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    w = predict_word(s);
    if (typed) begin
      canned.corr = w.corr;
      w = canned;
    end
    pending_words.push_back(w);
  endtask

  task automatic settle_down();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgW-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegSettleWait: cfg_m.settle_wait = data;
      RegSettleWin:  cfg_m.settle_window = data[8:0];
      RegDeadBand:   cfg_m.dead_band = data[7:0];
      RegPushOffset: cfg_m.push_offset = data[8:0];
      RegGain:       cfg_m.gain = data[4:0];
      RegStoredCorr: cfg_m.stored_corr = data[0];
      default: ;
    endcase
  endtask

  always @(negedge clk_i) begin
    out_ready_i <= calm ? 1'b1 : ($urandom_range(0, 99) >= 18);
  end

  always @(posedge clk_i) begin : check_words
    duty_word_t got;
    duty_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = {drive_duty_o, duty_valid_o, correction_on_o, save_setting_o, phase_o};
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected word: duty %0d valid %0b corr %0b save %0b phase %0d",
                   got.duty, got.valid, got.corr, got.save, got.phase);
        end
      end else begin
        want = pending_words.pop_front();
        if (got.duty !== want.duty || got.valid !== want.valid || got.corr !== want.corr ||
            got.save !== want.save || got.phase !== want.phase) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch (expected/actual): duty %0d/%0d valid %0b/%0b corr %0b/%0b",
                     want.duty, got.duty, want.valid, got.valid, want.corr, got.corr);
            $display("  save %0b/%0b phase %0d/%0d", want.save, got.save, want.phase, got.phase);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int                 seg;
    int                 n;
    int                 off;
    int                 t;
    int                 pick;
    logic [SampleW-1:0] s;
    logic [SampleW-1:0] target;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    position_sample_i = '0;
    out_ready_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    mismatches = 0;
    idle_cycles = 0;
    calm = 1'b0;

    cfg_m.settle_wait = 16'd20000;
    cfg_m.settle_window = 9'd128;
    cfg_m.dead_band = 8'd5;
    cfg_m.push_offset = 9'd60;
    cfg_m.gain = 5'd6;
    cfg_m.stored_corr = 1'b1;
    ph_m = PhaseInit;
    corr_m = 1'b1;
    settle_m = '0;
    acc_m = '0;
    center_m = '0;
    left_m = SamplesInit;

    // The first word decides the correction flag once per run, so its class is random.
    pick = $urandom_range(0, 3);
    case (pick)
      0:       s = 10'($urandom_range(0, 255));
      1:       s = 10'($urandom_range(768, 1023));
      default: s = 10'($urandom_range(256, 767));
    endcase

    // Upper data bits beyond each register's width must be dropped.
    plan_reg(RegSettleWait, 16'd6);
    plan_reg(RegSettleWin, 16'hFE64);
    plan_reg(RegDeadBand, 16'hFF05);
    plan_reg(RegPushOffset, 16'd60);
    plan_reg(RegGain, 16'd6);
    plan_reg(RegStoredCorr, CfgW'($urandom_range(0, 3) != 0));
    plan_reg(RegSpareLo, 16'hFFFF);
    plan_reg(RegSpareHi, 16'h0000);
    plan_sample(s, 1'b1, 1'b1, PhaseWait);
    plan_sample(10'd612, 1'b1, 1'b0, PhaseWait);   // on the window edge
    plan_sample(10'd411, 1'b1, 1'b0, PhaseWait);   // one past it, reloads
    plan_reg(RegSettleWait, 16'd0);
    plan_sample(10'd1023, 1'b1, 1'b0, PhaseWait);
    plan_sample(10'd412, 1'b1, 1'b0, PhaseWait);   // zero count wraps, no calibration
    plan_reg(RegSettleWin, 16'hFFFF);
    plan_sample(10'd0, 1'b1, 1'b0, PhaseWait);
    plan_sample(10'd1023, 1'b1, 1'b0, PhaseWait);
    plan_reg(RegSettleWin, 16'd0);
    plan_sample(10'd512, 1'b1, 1'b0, PhaseWait);
    plan_sample(10'd513, 1'b1, 1'b0, PhaseWait);
    plan_reg(RegSettleWait, 16'hFFFF);
    plan_sample(10'd511, 1'b1, 1'b0, PhaseWait);
    plan_reg(RegSettleWait, 16'd2);
    plan_reg(RegSettleWin, 16'd128);
    plan_sample(10'd700, 1'b1, 1'b0, PhaseWait);
    plan_sample(10'd384, 1'b1, 1'b0, PhaseWait);
    plan_sample(10'd640, 1'b1, 1'b0, PhaseCal);
    plan_sample(10'd0, 1'b1, 1'b0, PhaseCal);
    plan_sample(10'd1023, 1'b1, 1'b0, PhaseCal);

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < plan.size(); i++) begin
      if (plan[i].is_reg) begin
        if (i == 0 || !plan[i-1].is_reg) settle_down();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        drive_sample(plan[i].sample, plan[i].typed, plan[i].canned);
      end
    end

    // Calibration words scatter around a random center.
    target = 10'($urandom_range(0, 1023));
    while (ph_m == PhaseCal) begin
      off = $urandom_range(0, 96);
      t = int'(target) + off - 48;
      if (t < 0) t = 0;
      if (t > 1023) t = 1023;
      drive_sample(10'(t), 1'b0, '0);
    end

    for (seg = 0; seg < 8; seg++) begin
      settle_down();
      calm = (seg == 3 || seg == 4);
      case (seg)
        0: begin
          write_reg(RegDeadBand, 16'd5);
          write_reg(RegPushOffset, 16'd60);
          write_reg(RegGain, 16'd6);
        end
        1: begin
          write_reg(RegDeadBand, 16'd0);
          write_reg(RegPushOffset, 16'd0);
          write_reg(RegGain, 16'd8);
        end
        2: begin
          write_reg(RegDeadBand, 16'd255);
          write_reg(RegPushOffset, 16'd511);
          write_reg(RegGain, 16'hFFF0);
        end
        3: begin
          write_reg(RegDeadBand, 16'd0);
          write_reg(RegPushOffset, 16'd511);
          write_reg(RegGain, 16'd31);
        end
        4: begin
          write_reg(RegDeadBand, 16'd255);
          write_reg(RegPushOffset, 16'd0);
          write_reg(RegGain, 16'd0);
        end
        default: begin
          write_reg(RegSettleWait, CfgW'($urandom_range(0, 65535)));
          write_reg(RegSettleWin, CfgW'($urandom_range(0, 65535)));
          write_reg(RegDeadBand, CfgW'($urandom_range(0, 255)));
          write_reg(RegPushOffset, CfgW'($urandom_range(0, 511)));
          write_reg(RegGain, CfgW'($urandom_range(0, 31)));
        end
      endcase
      for (n = 0; n < 150; n++) begin
        case ($urandom_range(0, 5))
          0: s = $urandom_range(0, 1) ? 10'd1023 : 10'd0;
          1, 2: s = 10'($urandom_range(0, 1023));
          default: begin
            // Land near the center, around the edges of the dead band.
            off = $urandom_range(0, int'(cfg_m.dead_band) + 4);
            t = $urandom_range(0, 1) ? int'(center_m) + off : int'(center_m) - off;
            if (t < 0) t = 0;
            if (t > 1023) t = 1023;
            s = 10'(t);
          end
        endcase
        drive_sample(s, 1'b0, '0);
      end
    end
    calm = 1'b0;

    settle_down();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && pending_words.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
